FILE: rtl/core/qte_pkg.sv
package qte_pkg;

  // Fraction bits of the quaternion components and width of the output angles.
  localparam int QUAT_FRAC_BITS = 14;
  localparam int ANGLE_BITS     = 16;

  // Widths of the internal datapath.
  localparam int PROD_W  = 32;                    // one 16x16 signed product
  localparam int SUM_W   = 34;                    // sr, cr, sp, sy, cy
  localparam int VEC_W   = 40;                    // CORDIC x/y with growth margin
  localparam int TURN_W  = 32;                    // 2^32 is one full turn
  localparam int MAG_W   = QUAT_FRAC_BITS + 1;    // truncated pitch sine magnitude
  localparam int SQRT_STEPS = QUAT_FRAC_BITS + 1; // one root bit per step
  localparam int RAD_W   = 2 * SQRT_STEPS;
  localparam int REM_W   = RAD_W + 2;
  localparam int ROOT_W  = SQRT_STEPS + 1;

  localparam logic [TURN_W-1:0] QUARTER_TURN = TURN_W'(32'h4000_0000);

  // atan(2^-i) in turn units, rounded to nearest.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // One CORDIC vector in flight.
  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic        [TURN_W-1:0] z;
    logic                     zero;
  } vec_t;

  // Item state while the pitch cosine root is being formed.
  typedef struct packed {
    logic                     valid;
    logic                     sat;
    logic                     neg;
    logic signed [MAG_W:0]    s;
    logic        [RAD_W-1:0]  rad;
    logic        [REM_W-1:0]  rem;
    logic        [ROOT_W-1:0] root;
    logic signed [SUM_W-1:0]  sr;
    logic signed [SUM_W-1:0]  cr;
    logic signed [SUM_W-1:0]  sy;
    logic signed [SUM_W-1:0]  cy;
  } sqrt_t;

  // Item state in the CORDIC row: lane 0 roll, lane 1 pitch, lane 2 yaw.
  typedef struct packed {
    logic             valid;
    logic             sat;
    logic             neg;
    vec_t [2:0]       lane;
  } crd_t;

endpackage

FILE: rtl/core/quaternion_to_euler_unit.sv
// Pipeline: 20 + CORDIC_STAGES register stages (36 by default, with 15 square root steps).
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or its item is being taken, so in_tready follows out_tready.
// Reset (rst_n low at a clock edge) clears every stage valid bit; no item is
// pending afterwards.  Payload registers are not reset.
module quaternion_to_euler_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // quat_x [15:0], quat_y [31:16], quat_z [47:32], quat_w [63:48]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
  output logic        out_tuser   // pitch_saturated [0]
);
  import qte_pkg::*;

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(64'd1 << (2 * QUAT_FRAC_BITS));
  localparam logic [RAD_W-1:0]        ONE_R = RAD_W'(64'd1 << (2 * QUAT_FRAC_BITS));

  // The pipeline moves as a whole. It may advance when the output register is
  // empty or the downstream side takes its item in this cycle.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Axis permutation: working x is quat_z, y is quat_x, z is quat_y.
  logic signed [15:0] qx, qy, qz, qw;
  assign qy = in_tdata[15:0];
  assign qz = in_tdata[31:16];
  assign qx = in_tdata[47:32];
  assign qw = in_tdata[63:48];

  // Stage 1: the nine products.
  logic                     p_valid_r;
  logic signed [PROD_W-1:0] wx_r, yz_r, xx_r, yy_r, wy_r, zx_r, wz_r, xy_r, zz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (en) begin
      p_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= qw * qx;
      yz_r <= qy * qz;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      wy_r <= qw * qy;
      zx_r <= qz * qx;
      wz_r <= qw * qz;
      xy_r <= qx * qy;
      zz_r <= qz * qz;
    end
  end

  // Stage 2: the five trigonometric terms, exact with 2F fraction bits.
  logic                    t_valid_r;
  logic signed [SUM_W-1:0] sr_r, cr_r, sp_r, sy_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
    end else if (en) begin
      t_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r <= (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;
      cr_r <= ONE_S - ((SUM_W'(xx_r) + SUM_W'(yy_r)) <<< 1);
      sp_r <= (SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1;
      sy_r <= (SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1;
      cy_r <= ONE_S - ((SUM_W'(yy_r) + SUM_W'(zz_r)) <<< 1);
    end
  end

  // Stage 3: pitch clamp test, truncated sine and the radicand 1 - s^2.
  // When the sine is clamped the radicand is meaningless and never used.
  logic [SUM_W-1:0] sp_abs;
  logic [MAG_W-1:0] mag;
  logic             sp_neg;
  sqrt_t            sq [SQRT_STEPS+1];
  sqrt_t            sq0_nxt;

  assign sp_neg = sp_r[SUM_W-1];
  assign sp_abs = sp_neg ? SUM_W'(-sp_r) : SUM_W'(sp_r);
  assign mag    = sp_abs[QUAT_FRAC_BITS +: MAG_W];

  always_comb begin
    sq0_nxt       = '0;
    sq0_nxt.valid = t_valid_r;
    sq0_nxt.sat   = (sp_r >= ONE_S) || (sp_r <= -ONE_S);
    sq0_nxt.neg   = sp_neg;
    sq0_nxt.s     = sp_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sq0_nxt.rad   = ONE_R - RAD_W'(mag * mag);
    sq0_nxt.sr    = sr_r;
    sq0_nxt.cr    = cr_r;
    sq0_nxt.sy    = sy_r;
    sq0_nxt.cy    = cy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq[0].valid <= 1'b0;
    end else if (en) begin
      sq[0] <= sq0_nxt;
    end
  end

  // Square root row: each cell settles one bit of the pitch cosine.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qte_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (sq[i]),
      .q     (sq[i+1])
    );
  end

  // Quadrant pre-rotation: a vector in the left half-plane is turned by a
  // quarter turn so the CORDIC starts within its convergence range.
  function automatic vec_t pre_rot(input logic signed [VEC_W-1:0] y,
                                   input logic signed [VEC_W-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    v.x    = x;
    v.y    = y;
    v.z    = '0;
    if (x[VEC_W-1]) begin
      if (!y[VEC_W-1]) begin
        v.x = y;
        v.y = -x;
        v.z = QUARTER_TURN;
      end else begin
        v.x = -y;
        v.y = x;
        v.z = -QUARTER_TURN;
      end
    end
    return v;
  endfunction

  sqrt_t sqe;
  crd_t  crd [CORDIC_STAGES+1];
  crd_t  crd0_nxt;

  assign sqe = sq[SQRT_STEPS];

  always_comb begin
    crd0_nxt.valid   = sqe.valid;
    crd0_nxt.sat     = sqe.sat;
    crd0_nxt.neg     = sqe.neg;
    crd0_nxt.lane[0] = pre_rot(VEC_W'(sqe.sr), VEC_W'(sqe.cr));
    crd0_nxt.lane[1] = pre_rot(VEC_W'(sqe.s), VEC_W'(sqe.root));
    crd0_nxt.lane[2] = pre_rot(VEC_W'(sqe.sy), VEC_W'(sqe.cy));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crd[0].valid <= 1'b0;
    end else if (en) begin
      crd[0] <= crd0_nxt;
    end
  end

  // CORDIC row: one micro-rotation per cell on roll, pitch and yaw together.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qte_cordic_cell #(.STAGE(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (crd[i]),
      .q     (crd[i+1])
    );
  end

  // Output: zero vectors give angle zero, a clamped pitch is a signed quarter
  // turn, and each angle is rounded to the output width by adding half a unit.
  localparam logic [TURN_W-1:0] HALF_UNIT = TURN_W'(64'd1 << (TURN_W - ANGLE_BITS - 1));

  crd_t              crde;
  logic [TURN_W-1:0] z_fin [3];
  logic [TURN_W-1:0] z_rnd [3];
  logic [47:0]       data_nxt;

  assign crde = crd[CORDIC_STAGES];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      z_fin[k] = crde.lane[k].zero ? '0 : crde.lane[k].z;
    end
    if (crde.sat) begin
      z_fin[1] = crde.neg ? -QUARTER_TURN : QUARTER_TURN;
    end
    for (int k = 0; k < 3; k++) begin
      z_rnd[k] = z_fin[k] + HALF_UNIT;
      data_nxt[16*k +: 16] = z_rnd[k][TURN_W-1 -: ANGLE_BITS];
    end
  end

  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= crde.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= data_nxt;
      out_user_r <= crde.sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A clamped pitch is always exactly a quarter turn in either direction.
  a_sat_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (out_tdata[31:16] == 16'h4000) || (out_tdata[31:16] == 16'hC000))
    else $error("clamped pitch is not a quarter turn");

  // Input is taken exactly when the pipeline can advance.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow pipeline advance");

  // A stalled pipeline keeps the stage 1, stage 3 and CORDIC entry valid bits in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(crd[0].valid) && $stable(sq[0].valid) && $stable(p_valid_r))
    else $error("pipeline moved while stalled");

endmodule

FILE: rtl/core/qte_sqrt_cell.sv
module qte_sqrt_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  qte_pkg::sqrt_t d,
  output qte_pkg::sqrt_t q
);
  import qte_pkg::*;

  sqrt_t q_r, q_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  // One restoring step: bring down two radicand bits, try the next root bit.
  always_comb begin
    q_nxt  = d;
    rem_sh = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
    trial  = REM_W'({d.root, 2'b01});
    q_nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      q_nxt.rem  = rem_sh - trial;
      q_nxt.root = {d.root[ROOT_W-2:0], 1'b1};
    end else begin
      q_nxt.rem  = rem_sh;
      q_nxt.root = {d.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/core/qte_cordic_cell.sv
module qte_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  qte_pkg::crd_t d,
  output qte_pkg::crd_t q
);
  import qte_pkg::*;

  localparam logic [TURN_W-1:0] ATAN_STEP = ATAN_TURNS[STAGE];

  crd_t q_r, q_nxt;
  logic signed [VEC_W-1:0] dx [3];
  logic signed [VEC_W-1:0] dy [3];

  // One vectoring micro-rotation on each of the three lanes.
  always_comb begin
    q_nxt = d;
    for (int k = 0; k < 3; k++) begin
      dx[k] = d.lane[k].y >>> STAGE;
      dy[k] = d.lane[k].x >>> STAGE;
      if (!d.lane[k].y[VEC_W-1]) begin
        q_nxt.lane[k].x = d.lane[k].x + dx[k];
        q_nxt.lane[k].y = d.lane[k].y - dy[k];
        q_nxt.lane[k].z = d.lane[k].z + ATAN_STEP;
      end else begin
        q_nxt.lane[k].x = d.lane[k].x - dx[k];
        q_nxt.lane[k].y = d.lane[k].y + dy[k];
        q_nxt.lane[k].z = d.lane[k].z - ATAN_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The block converts one quaternion item into roll, pitch and yaw angles.
  // The bench keeps its own fixed-point model of that conversion, so every
  // result item is checked against a prediction made when its input was taken.

  localparam int FRAC = 14;
  localparam int ABITS = 16;
  localparam int STAGES = 16;
  localparam int NUM_RANDOM = 2000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic        sat;
  } euler_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;

  quaternion_to_euler_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Table of atan(2^-i); 2^32 is one full turn.
  localparam logic [31:0] ATAN_LUT [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Vectoring CORDIC. The >>> operator on signed values rounds toward minus
  // infinity, which is the rounding the block uses.
  function automatic longint vector_angle(longint yi, longint xi);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 64'sd1 << 30;
      end else begin
        x = -y;
        y = t;
        z = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_LUT[i]);
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_LUT[i]);
      end
    end
    return z;
  endfunction

  // Round a turn-unit angle to the output width and wrap it.
  function automatic logic [15:0] to_binary_angle(longint z);
    logic [63:0] u;
    u = 64'(z) + (64'd1 << (31 - ABITS));
    u = u >> (32 - ABITS);
    return u[15:0];
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r;
    r = 0;
    for (int b = 30; b >= 0; b--) begin
      if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= n) begin
        r += 64'sd1 << b;
      end
    end
    return r;
  endfunction

  function automatic euler_t predict_euler(logic [63:0] q);
    longint x;
    longint y;
    longint z;
    longint w;
    longint one;
    longint sr;
    longint cr;
    longint sp;
    longint sy;
    longint cy;
    longint mag;
    longint s;
    longint pz;
    euler_t e;
    // Axis permutation: working x is quat_z, y is quat_x, z is quat_y.
    y = longint'($signed(q[15:0]));
    z = longint'($signed(q[31:16]));
    x = longint'($signed(q[47:32]));
    w = longint'($signed(q[63:48]));
    one = 64'sd1 << (2 * FRAC);
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    e.sat = 1'b0;
    if (sp >= one || sp <= -one) begin
      // The pitch sine reached one: clamp to a quarter turn.
      pz = (sp > 0) ? (64'sd1 << 30) : -(64'sd1 << 30);
      e.sat = 1'b1;
    end else begin
      mag = ((sp < 0) ? -sp : sp) >> FRAC;
      s = (sp < 0) ? -mag : mag;
      pz = vector_angle(s, floor_sqrt(one - mag * mag));
    end
    e.roll = to_binary_angle(vector_angle(sr, cr));
    e.pitch = to_binary_angle(pz);
    e.yaw = to_binary_angle(vector_angle(sy, cy));
    return e;
  endfunction

  logic [63:0] pending_quats[$];
  euler_t      expected_angles[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          timed_out = 1'b0;
  bit          hold_sender;
  int          burst_left;
  int          gap_left;
  int          stall_phase;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Driver: items come in bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_angles.push_back(predict_euler(in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (hold_sender || pending_quats.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else begin
          in_tdata <= pending_quats.pop_front();
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver stalls on a rotating pattern: free running, periodic, random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 500) % 3)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= (stall_phase % 4) != 3;
        end
        default: begin
          out_tready <= $urandom_range(0, 2) != 0;
        end
      endcase
    end
  end

  // Monitor: compare each result item with the oldest prediction.
  always @(posedge clk) begin
    euler_t got;
    euler_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser};
      if (expected_angles.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result item %h", out_tdata);
        end
      end else begin
        want = expected_angles.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch roll %h/%h pitch %h/%h yaw %h/%h sat %b/%b (exp/got)",
                     want.roll, got.roll, want.pitch, got.pitch,
                     want.yaw, got.yaw, want.sat, got.sat);
          end
        end
      end
    end
  end

  // Watchdog: counts cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // A near-unit quaternion: one of a few standard poses plus small noise.
  function automatic logic [63:0] rand_unit_quat();
    int c[4];
    int k;
    k = $urandom_range(0, 3);
    foreach (c[i]) begin
      c[i] = int'($urandom_range(0, 2000)) - 1000;
    end
    c[k] += ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    return {16'(c[3]), 16'(c[2]), 16'(c[1]), 16'(c[0])};
  endfunction

  initial begin
    logic [15:0] qv;
    hold_sender = 1'b1;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: zero vector, identity, extremes, pitch sine just below
    // one of both signs, half turn roll and yaw.
    pending_quats.push_back(64'h0);
    pending_quats.push_back({16'sd16384, 48'h0});
    pending_quats.push_back({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pending_quats.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    pending_quats.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    pending_quats.push_back({16'd11585, 16'd0, 16'd0, 16'd11585});
    pending_quats.push_back({16'd11585, 16'd0, 16'd0, 16'(-11585)});
    pending_quats.push_back({16'd11584, 16'd0, 16'd0, 16'd11584});
    pending_quats.push_back({16'd0, 16'd16384, 16'd0, 16'd0});
    pending_quats.push_back({16'd0, 16'd0, 16'd16384, 16'd0});
    pending_quats.push_back({16'd0, 16'd0, 16'd0, 16'd16384});
    pending_quats.push_back({16'd0, 16'd0, 16'd0, 16'(-16384)});
    pending_quats.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_quats.push_back({16'h0001, 16'h0000, 16'h0000, 16'h0000});
    pending_quats.push_back({16'h0000, 16'h0001, 16'h0000, 16'h0000});
    pending_quats.push_back({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    hold_sender = 1'b0;

    // First half of the random part.
    for (int n = 0; n < NUM_RANDOM / 2; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        pending_quats.push_back(rand_unit_quat());
      end else begin
        pending_quats.push_back({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
      end
    end

    // Pause the sender once until the block has drained completely.
    wait (pending_quats.size() == 0);
    @(posedge clk);
    hold_sender = 1'b1;
    @(posedge clk);
    while (in_tvalid || expected_angles.size() != 0) @(posedge clk);
    hold_sender = 1'b0;

    for (int n = 0; n < NUM_RANDOM / 2; n++) begin
      if ($urandom_range(0, 3) != 0) begin
        pending_quats.push_back(rand_unit_quat());
      end else begin
        qv = 16'($urandom);
        pending_quats.push_back({qv, rand_comp(), rand_comp(), 16'($urandom)});
      end
    end

    wait (pending_quats.size() == 0);
    @(posedge clk);
    while (in_tvalid || expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: quaternion_to_euler_unit.f
rtl/core/qte_pkg.sv
rtl/core/qte_sqrt_cell.sv
rtl/core/qte_cordic_cell.sv
rtl/core/quaternion_to_euler_unit.sv
bench/tb_top.sv
